// ----- hw/rtl/dtlr_pkg.sv -----
package dtlr_pkg;

    localparam int COORD_W    = 6;
    localparam int ZW         = 24;
    localparam int ZI_W       = ZW + 2;
    localparam int COLOR_W    = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int DEPTH_BITS_DEF = 24;

    localparam logic [CFG_W-1:0] SCREEN_RESET = 7'd64;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_POINT = 2'd1,
        KIND_LINE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_TEST
    } state_t;

    typedef struct packed {
        logic load;
        logic point;
        logic advance;
    } step_ctrl_t;

    typedef struct packed {
        logic ready;
        logic last;
    } step_stat_t;

endpackage

// ----- hw/rtl/dtlr_ram.sv -----
module dtlr_ram #(
    parameter int WIDTH = dtlr_pkg::DEPTH_BITS_DEF,
    parameter int DEPTH = dtlr_pkg::MAX_WIDTH_DEF * dtlr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/dtlr_div.sv -----
module dtlr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dtlr_pkg::ZW-1:0]       dividend,
    input  logic [dtlr_pkg::COORD_W-1:0]  divisor,
    output logic                          done,
    output logic [dtlr_pkg::ZW-1:0]       quotient,
    output logic [dtlr_pkg::COORD_W-1:0]  remainder
);

    localparam int ZW    = dtlr_pkg::ZW;
    localparam int CW    = dtlr_pkg::COORD_W;
    localparam int CNT_W = $clog2(ZW);

    logic [ZW-1:0]    quo_reg, quo_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [CW:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[ZW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[ZW-2:0], fits};
            rem_next = fits ? CW'(shifted - {1'b0, den_reg}) : CW'(shifted);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ZW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/dtlr_step.sv -----
module dtlr_step (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dtlr_pkg::step_ctrl_t                 ctrl,
    input  logic [dtlr_pkg::COORD_W-1:0]         x_start,
    input  logic [dtlr_pkg::COORD_W-1:0]         y_start,
    input  logic signed [dtlr_pkg::ZW-1:0]       z_start,
    input  logic [dtlr_pkg::COORD_W-1:0]         x_end,
    input  logic [dtlr_pkg::COORD_W-1:0]         y_end,
    input  logic signed [dtlr_pkg::ZW-1:0]       z_end,
    output dtlr_pkg::step_stat_t                 stat,
    output logic [dtlr_pkg::COORD_W-1:0]         pixel_x,
    output logic [dtlr_pkg::COORD_W-1:0]         pixel_y,
    output logic signed [dtlr_pkg::ZI_W-1:0]     pixel_z
);

    localparam int CW   = dtlr_pkg::COORD_W;
    localparam int DW   = CW + 1;
    localparam int ZW   = dtlr_pkg::ZW;
    localparam int ZI_W = dtlr_pkg::ZI_W;

    // line setup
    logic signed [DW-1:0] dx, dy;
    logic [CW-1:0]        adx, ady, adm, n_load;
    logic                 x_major;
    logic signed [ZW:0]   dz;
    logic [ZW-1:0]        adz;

    logic                 div_done;
    logic [ZW-1:0]        qaz;
    logic [CW-1:0]        raz;

    // stepping state
    logic [CW-1:0]        maj_reg, maj_next;
    logic                 maj_neg_reg, maj_neg_next;
    logic [CW-1:0]        mbase_reg, mbase_next;
    logic                 mneg_reg, mneg_next;
    logic                 xmaj_reg, xmaj_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [CW-1:0]        qm_reg, qm_next;
    logic [CW-1:0]        rm_reg, rm_next;
    logic                 qam_reg, qam_next;
    logic [CW-1:0]        ram_reg, ram_next;
    logic signed [ZW-1:0] z1_reg, z1_next;
    logic                 zneg_reg, zneg_next;
    logic [ZW-1:0]        qz_reg, qz_next;
    logic [CW-1:0]        rz_reg, rz_next;
    logic                 ready_reg, ready_next;

    logic [DW-1:0]        rm_sum, rz_sum;
    logic                 m_carry, z_carry;
    logic [CW-1:0]        minor;
    logic signed [ZI_W-1:0] z1_ext, qz_ext;

    assign dx      = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    assign dy      = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    assign adx     = dx[DW-1] ? CW'(-dx) : CW'(dx);
    assign ady     = dy[DW-1] ? CW'(-dy) : CW'(dy);
    assign x_major = adx >= ady;
    assign n_load  = x_major ? adx : ady;
    assign adm     = x_major ? ady : adx;
    assign dz      = $signed({z_end[ZW-1], z_end}) - $signed({z_start[ZW-1], z_start});
    assign adz     = dz[ZW] ? ZW'(-dz) : ZW'(dz);

    dtlr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctrl.load && !ctrl.point),
        .dividend  (adz),
        .divisor   (n_load),
        .done      (div_done),
        .quotient  (qaz),
        .remainder (raz)
    );

    // remainder accumulators: each stays below n, so one compare and subtract
    assign rm_sum  = {1'b0, rm_reg} + {1'b0, ram_reg};
    assign m_carry = rm_sum >= {1'b0, n_reg};
    assign rz_sum  = {1'b0, rz_reg} + {1'b0, raz};
    assign z_carry = rz_sum >= {1'b0, n_reg};

    always_comb begin
        maj_next     = maj_reg;
        maj_neg_next = maj_neg_reg;
        mbase_next   = mbase_reg;
        mneg_next    = mneg_reg;
        xmaj_next    = xmaj_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        qm_next      = qm_reg;
        rm_next      = rm_reg;
        qam_next     = qam_reg;
        ram_next     = ram_reg;
        z1_next      = z1_reg;
        zneg_next    = zneg_reg;
        qz_next      = qz_reg;
        rz_next      = rz_reg;
        priority if (ctrl.load) begin
            k_next  = '0;
            qm_next = '0;
            rm_next = '0;
            qz_next = '0;
            rz_next = '0;
            z1_next = z_start;
            if (ctrl.point) begin
                maj_next     = x_start;
                maj_neg_next = 1'b0;
                mbase_next   = y_start;
                mneg_next    = 1'b0;
                xmaj_next    = 1'b1;
                n_next       = CW'(1);
                qam_next     = 1'b0;
                ram_next     = '0;
                zneg_next    = 1'b0;
            end else begin
                maj_next     = x_major ? x_start : y_start;
                maj_neg_next = x_major ? dx[DW-1] : dy[DW-1];
                mbase_next   = x_major ? y_start : x_start;
                mneg_next    = x_major ? dy[DW-1] : dx[DW-1];
                xmaj_next    = x_major;
                n_next       = n_load;
                qam_next     = adm == n_load;
                ram_next     = (adm == n_load) ? '0 : adm;
                zneg_next    = dz[ZW];
            end
        end else if (ctrl.advance) begin
            k_next   = k_reg + 1'b1;
            maj_next = maj_neg_reg ? maj_reg - 1'b1 : maj_reg + 1'b1;
            rm_next  = m_carry ? CW'(rm_sum - {1'b0, n_reg}) : CW'(rm_sum);
            qm_next  = qm_reg + CW'(qam_reg) + CW'(m_carry);
            rz_next  = z_carry ? CW'(rz_sum - {1'b0, n_reg}) : CW'(rz_sum);
            qz_next  = qz_reg + qaz + ZW'(z_carry);
        end else begin
        end
    end

    always_comb begin
        ready_next = ready_reg;
        priority if (ctrl.load) begin
            ready_next = ctrl.point;
        end else if (div_done) begin
            ready_next = 1'b1;
        end else begin
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= 1'b0;
        end else begin
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge aclk) begin
        maj_reg     <= maj_next;
        maj_neg_reg <= maj_neg_next;
        mbase_reg   <= mbase_next;
        mneg_reg    <= mneg_next;
        xmaj_reg    <= xmaj_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        qm_reg      <= qm_next;
        rm_reg      <= rm_next;
        qam_reg     <= qam_next;
        ram_reg     <= ram_next;
        z1_reg      <= z1_next;
        zneg_reg    <= zneg_next;
        qz_reg      <= qz_next;
        rz_reg      <= rz_next;
    end

    assign minor   = mneg_reg ? mbase_reg - qm_reg : mbase_reg + qm_reg;
    assign pixel_x = xmaj_reg ? maj_reg : minor;
    assign pixel_y = xmaj_reg ? minor : maj_reg;
    assign z1_ext  = ZI_W'(z1_reg);
    assign qz_ext  = $signed({2'b00, qz_reg});
    assign pixel_z = zneg_reg ? z1_ext - qz_ext : z1_ext + qz_ext;

    assign stat.ready = ready_reg;
    assign stat.last  = k_reg == CW'(n_reg - 1'b1);

endmodule

// ----- hw/rtl/depth_tested_line_raster_top.sv -----
// Channel   Ports                                   Moves
// s_        s_valid/s_ready, s_kind..s_draw_color   one clear, point or line item per transfer
// m_        m_valid/m_ready, m_pixel_x..m_last      one stepped pixel per transfer
// apb       psel/penable/pwrite/paddr/pwdata        screen_width at 0x0, screen_height at 0x4
//
// One item at a time. A point skips the divide; a line first runs the serial
// depth-slope divide, then spends a read and a test/write state of the depth RAM
// on each pixel of its major length. A clear sweeps every address of the RAM.
// After reset the same sweep runs before s_ready rises; register writes are taken anyway.
// A held result in the m_ output register stalls the pixel loop.
module depth_tested_line_raster_top #(
    parameter int MAX_WIDTH  = dtlr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtlr_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = dtlr_pkg::DEPTH_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dtlr_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dtlr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dtlr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dtlr_pkg::KIND_W-1:0]         s_kind,
    input  logic [dtlr_pkg::COORD_W-1:0]        s_x_start,
    input  logic [dtlr_pkg::COORD_W-1:0]        s_y_start,
    input  logic signed [dtlr_pkg::ZW-1:0]      s_z_start,
    input  logic [dtlr_pkg::COORD_W-1:0]        s_x_end,
    input  logic [dtlr_pkg::COORD_W-1:0]        s_y_end,
    input  logic signed [dtlr_pkg::ZW-1:0]      s_z_end,
    input  logic [dtlr_pkg::COLOR_W-1:0]        s_draw_color,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dtlr_pkg::COORD_W-1:0]        m_pixel_x,
    output logic [dtlr_pkg::COORD_W-1:0]        m_pixel_y,
    output logic [dtlr_pkg::COLOR_W-1:0]        m_pixel_color,
    output logic                                m_visible,
    output logic                                m_last
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CW          = dtlr_pkg::COORD_W;
    localparam int CFG_W       = dtlr_pkg::CFG_W;
    localparam int ZI_W        = dtlr_pkg::ZI_W;
    localparam int EXT_W       = (DEPTH_BITS > ZI_W) ? DEPTH_BITS : ZI_W;

    localparam logic [CFG_W-1:0] MAX_W = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H = CFG_W'(MAX_HEIGHT);

    localparam logic signed [EXT_W-1:0] DMAX = EXT_W'((64'sd1 <<< (DEPTH_BITS - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] DMIN = EXT_W'(-(64'sd1 <<< (DEPTH_BITS - 1)));
    localparam logic [DEPTH_BITS-1:0]   DEPTH_LOW = {1'b1, {(DEPTH_BITS - 1){1'b0}}};

    dtlr_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                    clr_addr_reg, clr_addr_next;
    logic                             hide_reg, hide_next;
    logic [dtlr_pkg::COLOR_W-1:0]     color_reg, color_next;
    logic [CFG_W-1:0]                 width_reg, width_next;
    logic [CFG_W-1:0]                 height_reg, height_next;

    logic                             m_valid_reg, m_valid_next;
    logic [CW-1:0]                    pixel_x_reg, pixel_y_reg;
    logic [dtlr_pkg::COLOR_W-1:0]     pixel_color_reg;
    logic                             visible_reg, last_reg;

    dtlr_pkg::step_ctrl_t             step_ctrl;
    dtlr_pkg::step_stat_t             step_stat;
    logic [CW-1:0]                    px, py;
    logic signed [ZI_W-1:0]           pz;

    logic                             mem_we, mem_re;
    logic [AW-1:0]                    mem_addr, pix_addr;
    logic [DEPTH_BITS-1:0]            mem_wdata, mem_rdata;

    logic                             zero_len, draw_kind, out_free, load_out;
    logic                             in_screen, depth_ok, vis;
    logic [CFG_W-1:0]                 w_eff, h_eff;
    logic signed [EXT_W-1:0]          z_ext, z_clip;
    logic signed [DEPTH_BITS-1:0]     z_sat;
    logic                             cfg_write;

    dtlr_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (step_ctrl),
        .x_start (s_x_start),
        .y_start (s_y_start),
        .z_start (s_z_start),
        .x_end   (s_x_end),
        .y_end   (s_y_end),
        .z_end   (s_z_end),
        .stat    (step_stat),
        .pixel_x (px),
        .pixel_y (py),
        .pixel_z (pz)
    );

    dtlr_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_depth_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign zero_len  = (s_x_start == s_x_end) && (s_y_start == s_y_end);
    assign draw_kind = (s_kind == dtlr_pkg::KIND_POINT) || (s_kind == dtlr_pkg::KIND_LINE);
    assign out_free  = !m_valid_reg || m_ready;

    assign w_eff     = (width_reg > MAX_W) ? MAX_W : width_reg;
    assign h_eff     = (height_reg > MAX_H) ? MAX_H : height_reg;
    assign in_screen = (CFG_W'(px) < w_eff) && (CFG_W'(py) < h_eff);
    assign pix_addr  = AW'(AW'(py) * AW'(MAX_WIDTH)) + AW'(px);

    assign z_ext    = EXT_W'(pz);
    assign z_clip   = (z_ext > DMAX) ? DMAX : ((z_ext < DMIN) ? DMIN : z_ext);
    assign z_sat    = DEPTH_BITS'(z_clip);
    assign depth_ok = !($signed(mem_rdata) > z_sat);
    assign vis      = in_screen && !hide_reg && depth_ok;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dtlr_pkg::ST_CLEAR: begin
                if (clr_addr_reg == AW'(STORE_DEPTH - 1)) begin
                    state_next = dtlr_pkg::ST_IDLE;
                end
            end
            dtlr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == dtlr_pkg::KIND_CLEAR) begin
                        state_next = dtlr_pkg::ST_CLEAR;
                    end else if (draw_kind) begin
                        state_next = dtlr_pkg::ST_SETUP;
                    end
                end
            end
            dtlr_pkg::ST_SETUP: begin
                if (step_stat.ready) begin
                    state_next = dtlr_pkg::ST_READ;
                end
            end
            dtlr_pkg::ST_READ: begin
                state_next = dtlr_pkg::ST_TEST;
            end
            dtlr_pkg::ST_TEST: begin
                if (out_free) begin
                    state_next = step_stat.last ? dtlr_pkg::ST_IDLE : dtlr_pkg::ST_READ;
                end
            end
            default: begin
                state_next = dtlr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = 1'b0;
        step_ctrl = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = pix_addr;
        mem_wdata = z_sat;
        load_out  = 1'b0;
        unique case (state_reg)
            dtlr_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = DEPTH_LOW;
            end
            dtlr_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                step_ctrl.load  = s_valid && draw_kind;
                step_ctrl.point = (s_kind == dtlr_pkg::KIND_POINT) || zero_len;
            end
            dtlr_pkg::ST_SETUP: begin
            end
            dtlr_pkg::ST_READ: begin
                mem_re = in_screen;
            end
            dtlr_pkg::ST_TEST: begin
                if (out_free) begin
                    load_out          = 1'b1;
                    mem_we            = vis;
                    step_ctrl.advance = !step_stat.last;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        clr_addr_next = clr_addr_reg;
        hide_next     = hide_reg;
        color_next    = color_reg;
        if (state_reg == dtlr_pkg::ST_CLEAR) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end else if (s_valid && s_ready) begin
            clr_addr_next = '0;
            hide_next     = (s_kind == dtlr_pkg::KIND_LINE) && zero_len;
            color_next    = s_draw_color;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                dtlr_pkg::REG_SCREEN_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                dtlr_pkg::REG_SCREEN_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dtlr_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            width_reg    <= dtlr_pkg::SCREEN_RESET;
            height_reg   <= dtlr_pkg::SCREEN_RESET;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
        end
    end

    always_ff @(posedge aclk) begin
        hide_reg  <= hide_next;
        color_reg <= color_next;
        if (load_out) begin
            pixel_x_reg     <= px;
            pixel_y_reg     <= py;
            pixel_color_reg <= color_reg;
            visible_reg     <= vis;
            last_reg        <= step_stat.last;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == dtlr_pkg::REG_SCREEN_HEIGHT)
                    ? dtlr_pkg::APB_DATA_W'(height_reg)
                    : dtlr_pkg::APB_DATA_W'(width_reg);

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = pixel_x_reg;
    assign m_pixel_y     = pixel_y_reg;
    assign m_pixel_color = pixel_color_reg;
    assign m_visible     = visible_reg;
    assign m_last        = last_reg;

endmodule

// ----- tb/depth_tested_line_raster_top_tb.sv -----
`timescale 1ns / 100ps
module depth_tested_line_raster_top_tb;

    localparam int KIND_W     = dtlr_pkg::KIND_W;
    localparam int COORD_W    = dtlr_pkg::COORD_W;
    localparam int ZW         = dtlr_pkg::ZW;
    localparam int COLOR_W    = dtlr_pkg::COLOR_W;
    localparam int CFG_W      = dtlr_pkg::CFG_W;
    localparam int CFG_ADDR_W = dtlr_pkg::CFG_ADDR_W;
    localparam int APB_DATA_W = dtlr_pkg::APB_DATA_W;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = dtlr_pkg::KIND_CLEAR;
    localparam logic [KIND_W-1:0] KIND_POINT  = dtlr_pkg::KIND_POINT;
    localparam logic [KIND_W-1:0] KIND_LINE   = dtlr_pkg::KIND_LINE;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int STORE_W = 64;
    localparam int STORE_H = 64;
    localparam logic signed [ZW-1:0] Z_MIN = {1'b1, {(ZW-1){1'b0}}};
    localparam logic signed [ZW-1:0] Z_MAX = {1'b0, {(ZW-1){1'b1}}};
    localparam logic [CFG_ADDR_W-1:0] ADDR_WIDTH  = {dtlr_pkg::REG_SCREEN_WIDTH, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_HEIGHT = {dtlr_pkg::REG_SCREEN_HEIGHT, 2'b00};
    localparam int SWEEP_SETTLE = 4300;
    localparam int N_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 60;

    typedef struct {
        logic [KIND_W-1:0]      kind;
        logic [COORD_W-1:0]     xs;
        logic [COORD_W-1:0]     ys;
        logic signed [ZW-1:0]   zs;
        logic [COORD_W-1:0]     xe;
        logic [COORD_W-1:0]     ye;
        logic signed [ZW-1:0]   ze;
        logic [COLOR_W-1:0]     color;
        bit                     typed;
        bit                     t_vis;
    } draw_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               vis;
        logic               last;
    } pixel_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_ONE_IN_FOUR, RX_MOSTLY} rx_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [KIND_W-1:0]      s_kind = '0;
    logic [COORD_W-1:0]     s_x_start = '0;
    logic [COORD_W-1:0]     s_y_start = '0;
    logic signed [ZW-1:0]   s_z_start = '0;
    logic [COORD_W-1:0]     s_x_end = '0;
    logic [COORD_W-1:0]     s_y_end = '0;
    logic signed [ZW-1:0]   s_z_end = '0;
    logic [COLOR_W-1:0]     s_draw_color = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [COORD_W-1:0]     m_pixel_x;
    logic [COORD_W-1:0]     m_pixel_y;
    logic [COLOR_W-1:0]     m_pixel_color;
    logic                   m_visible;
    logic                   m_last;

    depth_tested_line_raster_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic signed [ZW-1:0] depth_mirror [STORE_W*STORE_H];
    logic [CFG_W-1:0]     scr_w = dtlr_pkg::SCREEN_RESET;
    logic [CFG_W-1:0]     scr_h = dtlr_pkg::SCREEN_RESET;
    pixel_t               pending_pixels [$];
    draw_t                cur_item;

    int mismatches = 0;
    int n_results = 0, n_visible = 0;
    int n_lines = 0, n_points = 0, n_clears = 0, n_settings = 0;

    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_tick = 0;

    initial begin
        foreach (depth_mirror[i]) depth_mirror[i] = Z_MIN;
    end

    task automatic flag(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    function automatic bit depth_test(longint x, longint y, longint z);
        longint w, h, zc;
        int idx;
        w = (scr_w > STORE_W) ? STORE_W : scr_w;
        h = (scr_h > STORE_H) ? STORE_H : scr_h;
        if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
        idx = int'(x + y * STORE_W);
        zc = z;
        if (zc < longint'(Z_MIN)) zc = longint'(Z_MIN);
        if (zc > longint'(Z_MAX)) zc = longint'(Z_MAX);
        if (longint'(depth_mirror[idx]) > zc) return 1'b0;
        depth_mirror[idx] = zc[ZW-1:0];
        return 1'b1;
    endfunction

    function automatic void rasterize(input draw_t d, ref pixel_t out[$]);
        longint x1, y1, z1, dx, dy, dz, adx, ady, n, k, off, px, py, pz;
        bit vis;
        x1 = longint'(d.xs);
        y1 = longint'(d.ys);
        z1 = longint'(d.zs);
        case (d.kind)
            KIND_CLEAR: begin
                foreach (depth_mirror[i]) depth_mirror[i] = Z_MIN;
            end
            KIND_POINT: begin
                vis = depth_test(x1, y1, z1);
                out.push_back(pixel_t'{d.xs, d.ys, d.color, vis, 1'b1});
            end
            KIND_LINE: begin
                dx = longint'(d.xe) - x1;
                dy = longint'(d.ye) - y1;
                dz = longint'(d.ze) - z1;
                adx = dx < 0 ? -dx : dx;
                ady = dy < 0 ? -dy : dy;
                if (adx == 0 && ady == 0) begin
                    out.push_back(pixel_t'{d.xs, d.ys, d.color, 1'b0, 1'b1});
                end else begin
                    n = adx >= ady ? adx : ady;
                    for (k = 0; k < n; k++) begin
                        if (adx >= ady) begin
                            off = dx > 0 ? k : -k;
                            px = x1 + off;
                            py = y1 + (dy * off) / dx;
                            pz = z1 + (dz * off) / dx;
                        end else begin
                            off = dy > 0 ? k : -k;
                            py = y1 + off;
                            px = x1 + (dx * off) / dy;
                            pz = z1 + (dz * off) / dy;
                        end
                        vis = depth_test(px, py, pz);
                        out.push_back(pixel_t'{px[COORD_W-1:0], py[COORD_W-1:0], d.color,
                                               vis, k == n - 1});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin : scoreboard
        pixel_t want, got;
        pixel_t fresh [$];
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_WIDTH) scr_w = pwdata[CFG_W-1:0];
                else if (paddr == ADDR_HEIGHT) scr_h = pwdata[CFG_W-1:0];
            end
            if (m_valid && m_ready) begin
                got = pixel_t'{m_pixel_x, m_pixel_y, m_pixel_color, m_visible, m_last};
                n_results++;
                if (got.vis === 1'b1) n_visible++;
                if (pending_pixels.size() == 0) begin
                    flag($sformatf("unexpected pixel x=%0d y=%0d color=%h vis=%b last=%b",
                                   got.x, got.y, got.color, got.vis, got.last));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                        got.vis !== want.vis || got.last !== want.last) begin
                        flag($sformatf({"pixel want x=%0d y=%0d color=%h vis=%b last=%b,",
                                        " got x=%0d y=%0d color=%h vis=%b last=%b"},
                                       want.x, want.y, want.color, want.vis, want.last,
                                       got.x, got.y, got.color, got.vis, got.last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                fresh.delete();
                rasterize(cur_item, fresh);
                case (cur_item.kind)
                    KIND_CLEAR: n_clears++;
                    KIND_POINT: n_points++;
                    KIND_LINE:  n_lines++;
                    default: ;
                endcase
                if (cur_item.typed) begin
                    pending_pixels.push_back(pixel_t'{cur_item.xs, cur_item.ys, cur_item.color,
                                                      cur_item.t_vis, 1'b1});
                end else begin
                    foreach (fresh[i]) pending_pixels.push_back(fresh[i]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS:      m_ready <= 1'b1;
            RX_RANDOM:      m_ready <= 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: m_ready <= (rx_tick % 4) == 0;
            default:        m_ready <= (rx_tick % 7) < 5;
        endcase
    end

    task automatic send(input draw_t d);
        cur_item     <= d;
        s_kind       <= d.kind;
        s_x_start    <= d.xs;
        s_y_start    <= d.ys;
        s_z_start    <= d.zs;
        s_x_end      <= d.xe;
        s_y_end      <= d.ye;
        s_z_end      <= d.ze;
        s_draw_color <= d.color;
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic hold_off(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(bit wr, logic [CFG_ADDR_W-1:0] addr,
                              logic [APB_DATA_W-1:0] data, output logic [APB_DATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
    endtask

    task automatic set_screen(int w, int h, bit junk);
        logic [APB_DATA_W-1:0] dw, dh, rd;
        dw = w;
        dh = h;
        if (junk) begin
            dw = ($urandom() & ~32'h7F) | w;
            dh = ($urandom() & ~32'h7F) | h;
        end
        apb_access(1'b1, ADDR_WIDTH, dw, rd);
        apb_access(1'b1, ADDR_HEIGHT, dh, rd);
        apb_access(1'b0, ADDR_WIDTH, '0, rd);
        if (rd !== APB_DATA_W'(dw[CFG_W-1:0]))
            flag($sformatf("screen_width read %h, want %h", rd, dw[CFG_W-1:0]));
        apb_access(1'b0, ADDR_HEIGHT, '0, rd);
        if (rd !== APB_DATA_W'(dh[CFG_W-1:0]))
            flag($sformatf("screen_height read %h, want %h", rd, dh[CFG_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        n_settings++;
    endtask

    function automatic draw_t row(logic [KIND_W-1:0] kind, int xs, int ys,
                                  logic signed [ZW-1:0] zs, int xe, int ye,
                                  logic signed [ZW-1:0] ze, logic [COLOR_W-1:0] color,
                                  bit typed = 1'b0, bit vis = 1'b0);
        draw_t d;
        d.kind = kind;
        d.xs = COORD_W'(xs);
        d.ys = COORD_W'(ys);
        d.zs = zs;
        d.xe = COORD_W'(xe);
        d.ye = COORD_W'(ye);
        d.ze = ze;
        d.color = color;
        d.typed = typed;
        d.t_vis = vis;
        return d;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(bit hot);
        return hot ? COORD_W'($urandom_range(0, 7)) : COORD_W'($urandom_range(0, 63));
    endfunction

    function automatic logic signed [ZW-1:0] pick_depth();
        logic signed [ZW-1:0] z;
        case ($urandom_range(0, 9))
            0: z = Z_MIN;
            1: z = Z_MAX;
            2, 3, 4: z = ZW'($urandom());
            default: z = ZW'($urandom_range(0, 4000)) - ZW'(2000);
        endcase
        return z;
    endfunction

    function automatic draw_t random_item();
        draw_t d;
        int pick;
        bit hot;
        pick = $urandom_range(0, 99);
        hot = 1'($urandom_range(0, 1));
        d = row(KIND_LINE, pick_coord(hot), pick_coord(hot), pick_depth(),
                pick_coord(hot), pick_coord(hot), pick_depth(), COLOR_W'($urandom()));
        if (pick < 3) d.kind = KIND_CLEAR;
        else if (pick < 6) d.kind = KIND_UNUSED;
        else if (pick < 36) d.kind = KIND_POINT;
        else if (pick < 44) begin
            d.xe = d.xs;
            d.ye = d.ys;
        end
        return d;
    endfunction

    initial begin : timeout
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        draw_t table_rows [$];
        draw_t d;
        int cfg_w [N_PHASES] = '{64, 1, 0, 127, 23, 64, 2, 0};
        int cfg_h [N_PHASES] = '{64, 1, 64, 127, 41, 0, 1, 0};
        int counted, burst;
        bit gaps, paused;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        rx_mode <= RX_RANDOM;

        table_rows.push_back(row(KIND_POINT, 0, 0, Z_MIN, 0, 0, 0, 16'h0000, 1, 1));
        table_rows.push_back(row(KIND_POINT, 63, 63, Z_MAX, 0, 0, 0, 16'hFFFF, 1, 1));
        table_rows.push_back(row(KIND_POINT, 63, 63, 0, 0, 0, 0, 16'h00F0, 1, 0));
        table_rows.push_back(row(KIND_POINT, 63, 63, Z_MAX, 0, 0, 0, 16'h0F00, 1, 1));
        // point ignores the end fields
        table_rows.push_back(row(KIND_POINT, 0, 0, Z_MIN, 63, 63, Z_MAX, 16'h8001, 1, 1));
        table_rows.push_back(row(KIND_LINE, 10, 20, 5, 10, 20, 9, 16'h1234, 1, 0));
        table_rows.push_back(row(KIND_LINE, 0, 0, Z_MIN, 63, 0, Z_MAX, 16'hAAAA));
        table_rows.push_back(row(KIND_LINE, 63, 0, Z_MAX, 0, 0, Z_MIN, 16'h5555));
        table_rows.push_back(row(KIND_LINE, 63, 63, 1000, 0, 0, -1000, 16'h0001));
        table_rows.push_back(row(KIND_LINE, 5, 0, -300, 7, 63, 300, 16'h0002));
        table_rows.push_back(row(KIND_LINE, 40, 60, 0, 2, 10, Z_MAX, 16'h0004));
        table_rows.push_back(row(KIND_LINE, 0, 63, Z_MIN, 63, 30, 0, 16'h0008));
        table_rows.push_back(row(KIND_LINE, 1, 1, 77, 2, 1, 99, 16'h0010));
        table_rows.push_back(row(KIND_LINE, 0, 5, -5, 0, 62, 5, 16'h0020));
        table_rows.push_back(row(KIND_LINE, 30, 30, Z_MAX, 31, 62, Z_MIN, 16'h0040));
        table_rows.push_back(row(KIND_UNUSED, 63, 63, Z_MAX, 63, 63, Z_MIN, 16'hFFFF));
        table_rows.push_back(row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 16'h0000));
        table_rows.push_back(row(KIND_POINT, 63, 63, Z_MIN, 0, 0, 0, 16'hC0DE, 1, 1));
        table_rows.push_back(row(KIND_POINT, 0, 0, Z_MIN, 0, 0, 0, 16'h0BAD, 1, 1));
        table_rows.push_back(row(KIND_LINE, 0, 0, 24'h555555, 63, 63, 24'hAAAAAA, 16'h0080));
        table_rows.push_back(row(KIND_POINT, 32, 16, 24'hAAAAAA, 21, 42, 0, 16'h5555));
        foreach (table_rows[i]) send(table_rows[i]);

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            // a trailing clear gives no result, so let its sweep finish
            repeat (SWEEP_SETTLE) @(posedge aclk);
            if (p == N_PHASES - 1) set_screen($urandom_range(0, 127), $urandom_range(0, 127), 1);
            else set_screen(cfg_w[p], cfg_h[p], 1'(p % 2));
            rx_mode <= rx_mode_t'(p % 4);
            gaps = (p % 3) != 0;
            counted = 0;
            burst = 0;
            paused = 1'b0;
            while (counted < ITEMS_PER_PHASE) begin
                if (!paused && counted == ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if (gaps && burst == 0) begin
                    burst = $urandom_range(1, 10);
                    hold_off($urandom_range(1, 8));
                end
                d = random_item();
                send(d);
                if (gaps) burst--;
                if (d.kind != KIND_UNUSED) counted++;
            end
        end

        drain();
        repeat (SWEEP_SETTLE) @(posedge aclk);
        $display("ran %0d lines, %0d points, %0d clears over %0d screen settings",
                 n_lines, n_points, n_clears, n_settings + 1);
        $display("checked %0d pixels (%0d visible), %0d mismatches",
                 n_results, n_visible, mismatches);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/dtlr_pkg.sv
hw/rtl/dtlr_ram.sv
hw/rtl/dtlr_div.sv
hw/rtl/dtlr_step.sv
hw/rtl/depth_tested_line_raster_top.sv
tb/depth_tested_line_raster_top_tb.sv
